// ===== rtl/core/rttt_pkg.sv =====
// package of the retransmit / time-wait timer table
// types, codes and default sizes shared by every module of the block but rttt_ram; no dependencies
`default_nettype none

package rttt_pkg;

   // default sizes, handed down from the top level
   localparam int SLOTS_DEF      = 16;
   localparam int COUNT_BITS_DEF = 32;
   localparam int QUEUE_DEPTH    = 2;

   // at most this many results are reported per tick
   localparam int MAX_RESULTS  = 16;
   localparam int RES_CNT_BITS = $clog2(MAX_RESULTS + 1);

   // configuration port
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TIMEWAIT    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RETRANSMIT  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RETRY_LIMIT = 2'd2;

   // operation codes on the request word
   localparam logic [2:0] OP_TICK     = 3'd0;
   localparam logic [2:0] OP_ARM_TW   = 3'd1;
   localparam logic [2:0] OP_ARM_RT   = 3'd2;
   localparam logic [2:0] OP_RESTART  = 3'd3;
   localparam logic [2:0] OP_SET_HEAD = 3'd4;

   // event codes on the response word
   localparam logic [1:0] EV_ACK        = 2'd0;
   localparam logic [1:0] EV_CLOSE      = 2'd1;
   localparam logic [1:0] EV_RETRANSMIT = 2'd2;
   localparam logic [1:0] EV_GIVE_UP    = 2'd3;

   // decoded command, as queued between front and back
   typedef enum logic [2:0] {
      CMD_TICK,
      CMD_ARM_TW,
      CMD_ARM_RT,
      CMD_RESTART,
      CMD_SET_HEAD,
      CMD_NOP,
      CMD_BAD_SLOT
   } rttt_cmd_code_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [3:0] slot;
      logic       pending;
   } rttt_req_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic [3:0] event_slot;
      logic [3:0] retry_count;
      logic       last;
   } rttt_rsp_type;

   typedef struct packed {
      rttt_cmd_code_type code;
      logic [3:0]        slot;
      logic              pending;
   } rttt_cmd_type;

   typedef struct packed {
      logic [15:0] timewait_ticks;
      logic [15:0] retransmit_ticks;
      logic [3:0]  retry_limit;
   } rttt_cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } rttt_q_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_FLUSH
   } rttt_back_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/rttt_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module rttt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rttt_front.sv =====
// front end: takes request words and decodes them into queued commands
// depends on rttt_pkg
`default_nettype none

module rttt_front import rttt_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF
) (
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire rttt_req_type      req_data,
   input  wire rttt_q_status_type q_status,
   output logic                   push,
   output rttt_cmd_type           push_cmd
);

   // stall only on a full queue
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   // classify the operation; out-of-range slots are answered with a plain ack
   always_comb begin
      push_cmd.slot    = req_data.slot;
      push_cmd.pending = req_data.pending;
      if (req_data.operation == OP_TICK) begin
         push_cmd.code = CMD_TICK;
      end else if (int'(req_data.slot) >= SLOTS) begin
         push_cmd.code = CMD_BAD_SLOT;
      end else begin
         case (req_data.operation)
            OP_ARM_TW:   push_cmd.code = CMD_ARM_TW;
            OP_ARM_RT:   push_cmd.code = CMD_ARM_RT;
            OP_RESTART:  push_cmd.code = CMD_RESTART;
            OP_SET_HEAD: push_cmd.code = CMD_SET_HEAD;
            default:     push_cmd.code = CMD_NOP;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/rttt_queue.sv =====
// short command queue between front end and back end
// depends on rttt_pkg
`default_nettype none

module rttt_queue import rttt_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire rttt_cmd_type  push_cmd,
   input  wire logic          pop,
   output rttt_cmd_type       pop_cmd,
   output rttt_q_status_type  q_status
);

   localparam int PTR_BITS = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   rttt_cmd_type        entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
      logic [PTR_BITS-1:0] r;
      if (p == PTR_BITS'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_BITS'(1);
      end
      return r;
   endfunction

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd        = entry_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == CNT_BITS'(DEPTH));
   assign q_status.empty = (count_ff == '0);

endmodule

`default_nettype wire

// ===== rtl/core/rttt_back.sv =====
// back end: carries out queued commands against the slot table and drives responses
// depends on rttt_pkg and rttt_ram
`default_nettype none

module rttt_back import rttt_pkg::*; #(
   parameter int SLOTS      = SLOTS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rttt_cfg_type      cfg,
   input  wire rttt_q_status_type q_status,
   output logic                   pop,
   input  wire rttt_cmd_type      pop_cmd,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rttt_rsp_type           rsp_data
);

   localparam int SLOT_BITS  = SLOTS > 1 ? $clog2(SLOTS) : 1;
   localparam int SW_BITS    = SLOT_BITS + 4;
   localparam int ENTRY_BITS = COUNT_BITS + 6;
   localparam int WIDE_BITS  = COUNT_BITS > 31 ? COUNT_BITS : 31;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   rttt_back_state_type state_ff, state_in;
   rttt_cmd_type         cmd_ff, cmd_in;
   logic [SLOT_BITS-1:0] cur_ff, cur_in;
   logic [SLOTS-1:0]     active_ff, active_in;
   logic [SLOTS-1:0]     written_ff, written_in;
   logic                 hold_valid_ff, hold_valid_in;
   rttt_rsp_type         hold_ff, hold_in;
   logic [RES_CNT_BITS-1:0] n_ff, n_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rttt_rsp_type         rsp_ff, rsp_in;

   logic [ENTRY_BITS-1:0] rd_raw, rd_word, wr_word;
   logic                  wr_en;
   logic                  old_kind, new_kind, new_pend, old_pend;
   logic [COUNT_BITS-1:0] old_rem, new_rem;
   logic [3:0]            old_retries, new_retries, bump_retries;
   logic                  old_active, new_active;
   logic                  do_write;
   logic [1:0]            ev;
   logic [WIDE_BITS-1:0]  tw_wide, rt_wide, backoff_wide;
   logic [COUNT_BITS-1:0] tw_load, rt_load, reload;
   logic [SW_BITS-1:0]    slot_wide, cur_wide;
   logic [SLOT_BITS-1:0]  pop_idx;
   logic                  is_tick, report, need_out, out_free, advance, at_end;
   rttt_rsp_type          result;

   // slot storage: kind, count, retries and pending per slot
   rttt_ram #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(SLOTS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(cur_ff),
      .wr_data(wr_word),
      .rd_addr(cur_in),
      .rd_data(rd_raw)
   );

   // entries never written read as zero
   assign rd_word     = written_ff[cur_ff] ? rd_raw : '0;
   assign old_kind    = rd_word[ENTRY_BITS-1];
   assign old_rem     = rd_word[COUNT_BITS+4:5];
   assign old_retries = rd_word[4:1];
   assign old_pend    = rd_word[0];
   assign old_active  = active_ff[cur_ff];
   assign wr_word     = {new_kind, new_rem, new_retries, new_pend};

   // reload values: register loads masked to the count width, and the doubled backoff
   assign tw_wide      = WIDE_BITS'(cfg.timewait_ticks);
   assign rt_wide      = WIDE_BITS'(cfg.retransmit_ticks);
   assign tw_load      = tw_wide[COUNT_BITS-1:0];
   assign rt_load      = rt_wide[COUNT_BITS-1:0];
   assign bump_retries = old_retries + 4'd1;
   assign backoff_wide = rt_wide << bump_retries;
   assign reload       = (backoff_wide >= WIDE_BITS'(COUNT_MAX)) ? COUNT_MAX
                                                                : backoff_wide[COUNT_BITS-1:0];

   // slot index conversions
   assign slot_wide = SW_BITS'(pop_cmd.slot);
   assign pop_idx   = slot_wide[SLOT_BITS-1:0];
   assign cur_wide  = SW_BITS'(cur_ff);

   assign is_tick  = (cmd_ff.code == CMD_TICK);
   assign at_end   = (cur_ff == SLOT_BITS'(SLOTS - 1));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // slot update for the current command
   always_comb begin
      new_kind    = old_kind;
      new_rem     = old_rem;
      new_retries = old_retries;
      new_pend    = old_pend;
      new_active  = old_active;
      do_write    = 1'b0;
      ev          = EV_ACK;
      case (cmd_ff.code)
         CMD_TICK: begin
            if (old_active) begin
               do_write = 1'b1;
               if (old_rem > COUNT_BITS'(1)) begin
                  new_rem = old_rem - COUNT_BITS'(1);
               end else begin
                  new_rem = '0;
                  if (!old_kind) begin
                     new_active = 1'b0;
                     ev         = EV_CLOSE;
                  end else if (old_pend) begin
                     if (old_retries >= cfg.retry_limit) begin
                        new_active = 1'b0;
                        ev         = EV_GIVE_UP;
                     end else begin
                        new_retries = bump_retries;
                        new_rem     = reload;
                        ev          = EV_RETRANSMIT;
                     end
                  end
               end
            end
         end
         CMD_ARM_TW: begin
            do_write    = 1'b1;
            new_active  = 1'b1;
            new_kind    = 1'b0;
            new_rem     = tw_load;
            new_retries = '0;
         end
         CMD_ARM_RT: begin
            do_write    = 1'b1;
            new_active  = 1'b1;
            new_kind    = 1'b1;
            new_rem     = rt_load;
            new_retries = '0;
         end
         CMD_RESTART: begin
            if (old_active && old_kind) begin
               do_write = 1'b1;
               new_rem  = rt_load;
            end
         end
         CMD_SET_HEAD: begin
            do_write    = 1'b1;
            new_pend    = cmd_ff.pending;
            new_retries = '0;
         end
         default: begin
         end
      endcase
   end

   // result for this slot or command
   always_comb begin
      result.last = !is_tick;
      if (is_tick) begin
         result.event_res   = ev;
         result.event_slot  = cur_wide[3:0];
         result.retry_count = new_retries;
      end else begin
         result.event_res   = EV_ACK;
         result.event_slot  = cmd_ff.slot;
         result.retry_count = (cmd_ff.code == CMD_BAD_SLOT) ? 4'd0 : new_retries;
      end
   end

   // a tick result waits in the hold register until the next one or the end of the scan
   assign report   = (ev != EV_ACK) && (n_ff < RES_CNT_BITS'(MAX_RESULTS));
   assign need_out = is_tick ? (report && hold_valid_ff) : 1'b1;
   assign advance  = !need_out || out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (!q_status.empty) state_in = ST_READ;
         ST_READ:  state_in = ST_EXEC;
         ST_EXEC: begin
            if (advance) begin
               if (!is_tick) begin
                  state_in = ST_IDLE;
               end else if (at_end) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath registers
   always_comb begin
      pop           = 1'b0;
      wr_en         = 1'b0;
      cmd_in        = cmd_ff;
      cur_in        = cur_ff;
      active_in     = active_ff;
      written_in    = written_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      n_in          = n_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop           = 1'b1;
               cmd_in        = pop_cmd;
               cur_in        = (pop_cmd.code == CMD_TICK) ? '0 : pop_idx;
               hold_valid_in = 1'b0;
               n_in          = '0;
            end
         end
         ST_EXEC: begin
            if (advance) begin
               wr_en = do_write;
               if (do_write) begin
                  active_in[cur_ff]  = new_active;
                  written_in[cur_ff] = 1'b1;
               end
               if (!is_tick) begin
                  rsp_in       = result;
                  rsp_valid_in = 1'b1;
               end else begin
                  if (report) begin
                     if (hold_valid_ff) begin
                        rsp_in       = hold_ff;
                        rsp_valid_in = 1'b1;
                     end
                     hold_in       = result;
                     hold_valid_in = 1'b1;
                     n_in          = n_ff + RES_CNT_BITS'(1);
                  end
                  if (!at_end) begin
                     cur_in = cur_ff + SLOT_BITS'(1);
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (hold_valid_ff) begin
                  rsp_in      = hold_ff;
                  rsp_in.last = 1'b1;
               end else begin
                  rsp_in = '{event_res: EV_ACK, event_slot: 4'd0, retry_count: 4'd0,
                             last: 1'b1};
               end
               hold_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= '0;
         written_ff    <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         n_ff          <= '0;
         cur_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         written_ff    <= written_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         n_ff          <= n_in;
         cur_ff        <= cur_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/retransmit_timewait_timer_table_top.sv =====
// retransmit / time-wait timer table, top level: configuration registers and the
// front end, command queue and back end. a non-tick word gives its single response;
// a tick scans the slot ram one slot per cycle while the response output is not
// stalled. synchronous active-high reset empties the queue, frees every slot and
// restores the register defaults; slot contents read as zero until first written
`default_nettype none

module retransmit_timewait_timer_table_top import rttt_pkg::*; #(
   parameter int SLOTS      = SLOTS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire rttt_req_type             req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rttt_rsp_type                  rsp_data,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   rttt_cfg_type      cfg_ff, cfg_in;
   rttt_q_status_type q_status;
   rttt_cmd_type      push_cmd, pop_cmd;
   logic              push, pop;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TIMEWAIT:    cfg_in.timewait_ticks   = csr_wdata;
            CSR_RETRANSMIT:  cfg_in.retransmit_ticks = csr_wdata;
            CSR_RETRY_LIMIT: cfg_in.retry_limit      = csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timewait_ticks   <= 16'd60;
         cfg_ff.retransmit_ticks <= 16'd2;
         cfg_ff.retry_limit      <= 4'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rttt_front #(
      .SLOTS(SLOTS)
   ) u_front (
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .q_status (q_status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   rttt_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .pop     (pop),
      .pop_cmd (pop_cmd),
      .q_status(q_status)
   );

   rttt_back #(
      .SLOTS     (SLOTS),
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_status (q_status),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/core/rttt_checker.sv =====
// port-level checks for the timer table, bound to the top level
// depends on rttt_pkg and retransmit_timewait_timer_table_top
`default_nettype none

module rttt_checker import rttt_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rttt_rsp_type rsp_data
);

   // reset leaves no response and an open input
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response or stall present after reset");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response word changed");

   // acks and idle tick answers always close their request
   a_ack_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_res == EV_ACK) |-> rsp_data.last)
      else $error("ack word without last");

   // a retransmit always reports at least one retry
   a_rt_retries: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_res == EV_RETRANSMIT) |-> rsp_data.retry_count != 4'd0)
      else $error("retransmit word with zero retry count");

endmodule

bind retransmit_timewait_timer_table_top rttt_checker u_rttt_checker (
   .clock    (clock),
   .reset    (reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

`default_nettype wire
